// File: hw/rtl/tea_pkg.sv
// Package: shared types, constants and round-sum helper for the TEA cipher pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  localparam int unsigned CYCLES = 32;
  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3 = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
  } key_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
  } stage_t;

  typedef struct packed {
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
  } result_t;

  // delta times a small count, wrapped to one word
  function automatic logic [WORD_W-1:0] sum_at(input int unsigned mult);
    logic [63:0] prod;
    prod = 64'(mult) * 64'(DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tea_cell.sv
// One half-round cell of the TEA pipeline: updates one half of the block from the other.
`timescale 1ns / 1ps
`default_nettype none

module tea_cell #(
  parameter logic [tea_pkg::WORD_W-1:0] SUM_ENC = tea_pkg::DELTA,
  parameter logic [tea_pkg::WORD_W-1:0] SUM_DEC = tea_pkg::DELTA,
  parameter bit                         ODD     = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire tea_pkg::key_t   key,
  input  wire tea_pkg::stage_t d,
  output tea_pkg::stage_t      q
);

  logic                       upd_low;
  logic                       is_dec;
  logic [tea_pkg::WORD_W-1:0] sum;
  logic [tea_pkg::WORD_W-1:0] v;
  logic [tea_pkg::WORD_W-1:0] dst;
  logic [tea_pkg::WORD_W-1:0] ka;
  logic [tea_pkg::WORD_W-1:0] kb;
  logic [tea_pkg::WORD_W-1:0] mix;
  logic [tea_pkg::WORD_W-1:0] res;

  // encrypt: even cell updates low, odd updates high; decrypt is the reverse
  always_comb begin
    is_dec  = (d.kind == tea_pkg::KIND_DEC);
    upd_low = d.kind ^ ~ODD;
    sum     = is_dec ? SUM_DEC : SUM_ENC;
    v       = upd_low ? d.high : d.low;
    dst     = upd_low ? d.low : d.high;
    ka      = upd_low ? key.w0 : key.w2;
    kb      = upd_low ? key.w1 : key.w3;
    mix     = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    res     = is_dec ? (dst - mix) : (dst + mix);
  end

  // valid is cleared by reset, the data fields are not
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
      q.kind  <= d.kind;
      q.low   <= upd_low ? res : d.low;
      q.high  <= upd_low ? d.high : res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tea_obuf.sv
// Two-entry output buffer that decouples the cipher pipeline from the result consumer.
`timescale 1ns / 1ps
`default_nettype none

module tea_obuf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tea_pkg::result_t d,
  input  wire logic             pop_ready,
  output logic                  out_valid,
  output tea_pkg::result_t      q,
  output logic                  room
);

  tea_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && pop_ready;
  assign room      = (count != 2'd2) || pop;
  assign q         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("push into full output buffer");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> rd_ptr != $past(rd_ptr) && count == $past(count) - 2'd1)
    else $error("pop did not advance output buffer");

endmodule

`default_nettype wire

// File: hw/rtl/tea_block_cipher.sv
// Top level of the TEA block cipher: key registers, half-round cell chain, output buffer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  config   | wr_en                | wr_index, wr_data (key words 0..3)
//  request  | in_valid / in_ready  | kind, block_low, block_high
//  result   | out_valid / out_ready| result_low, result_high
//
// One request per clock while in_ready is high; a chain of 2*CYCLES half-round cells, one register each.
// An accepted request passes through every cell register and then the output buffer before its result is valid.
// Synchronous active-high reset clears the key words, cell valid bits and buffer.
// A stalled result consumer freezes the chain only once the two-entry buffer is full.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher #(
  parameter int unsigned CYCLES = tea_pkg::CYCLES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [tea_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [tea_pkg::WORD_W-1:0]    wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [tea_pkg::WORD_W-1:0]    block_low,
  input  wire logic [tea_pkg::WORD_W-1:0]    block_high,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tea_pkg::WORD_W-1:0]         result_low,
  output logic [tea_pkg::WORD_W-1:0]         result_high
);

  localparam int unsigned STAGES = 2 * CYCLES;

  tea_pkg::key_t    key;
  tea_pkg::stage_t  st [0:STAGES];
  tea_pkg::result_t last_res;
  tea_pkg::result_t buf_q;
  logic             advance;
  logic             room;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      case (wr_index)
        tea_pkg::REG_KEY0: key.w0 <= wr_data;
        tea_pkg::REG_KEY1: key.w1 <= wr_data;
        tea_pkg::REG_KEY2: key.w2 <= wr_data;
        tea_pkg::REG_KEY3: key.w3 <= wr_data;
        default: ;
      endcase
    end
  end

  assign advance  = !st[STAGES].valid || room;
  assign in_ready = advance;

  always_comb begin
    st[0].valid = in_valid;
    st[0].kind  = kind;
    st[0].low   = block_low;
    st[0].high  = block_high;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    localparam int unsigned N = i / 2;
    tea_cell #(
      .SUM_ENC (tea_pkg::sum_at(N + 1)),
      .SUM_DEC (tea_pkg::sum_at(CYCLES - N)),
      .ODD     ((i % 2) == 1)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .key (key),
      .d   (st[i]),
      .q   (st[i+1])
    );
  end

  assign last_res.low  = st[STAGES].low;
  assign last_res.high = st[STAGES].high;

  tea_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (st[STAGES].valid && advance),
    .d         (last_res),
    .pop_ready (out_ready),
    .out_valid (out_valid),
    .q         (buf_q),
    .room      (room)
  );

  assign result_low  = buf_q.low;
  assign result_high = buf_q.high;

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> st[1].valid)
    else $error("accepted request missing from first cell");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> st[STAGES].valid && $stable(st[STAGES].low) && $stable(st[STAGES].high))
    else $error("last cell changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request side stalled without a stalled result");

endmodule

`default_nettype wire

// File: tb/tea_block_cipher_tb.sv
// Self-checking testbench for the TEA block cipher: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tea_block_cipher_tb;
  import tea_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
  } block_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = REG_KEY0;
  logic [WORD_W-1:0]    wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = KIND_ENC;
  logic [WORD_W-1:0]    block_low = '0;
  logic [WORD_W-1:0]    block_high = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    result_low;
  logic [WORD_W-1:0]    result_high;

  block_req_t pending_reqs[$];
  result_t    results_due[$];
  key_t       key_copy = '0;
  logic       request_taken = 1'b0;
  int         mismatch_count = 0;
  int         burst_left = 8;
  int         gap_left = 0;
  int         ready_mode = 0;
  int         ready_left = 0;

  tea_block_cipher i_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .block_low  (block_low),
    .block_high (block_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_low (result_low),
    .result_high(result_high)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] round_mix(logic [WORD_W-1:0] v, logic [WORD_W-1:0] sum,
                                                  logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
    logic [WORD_W-1:0] shl;
    logic [WORD_W-1:0] shr;
    shl = v << 4;
    shr = v >> 5;
    return (shl + ka) ^ (v + sum) ^ (shr + kb);
  endfunction

  function automatic result_t tea_cipher(logic dir, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                                         key_t k);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    logic [63:0]       wide;
    result_t           res;
    y = lo;
    z = hi;
    if (dir == KIND_ENC) begin
      sum = DELTA;
      for (int n = 0; n < CYCLES; n++) begin
        y = y + round_mix(z, sum, k.w0, k.w1);
        z = z + round_mix(y, sum, k.w2, k.w3);
        sum = sum + DELTA;
      end
    end else begin
      wide = 64'(CYCLES) * 64'(DELTA);
      sum = wide[WORD_W-1:0];
      for (int n = 0; n < CYCLES; n++) begin
        z = z - round_mix(y, sum, k.w2, k.w3);
        y = y - round_mix(z, sum, k.w0, k.w1);
        sum = sum - DELTA;
      end
    end
    res.low = y;
    res.high = z;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    block_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || request_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        kind <= nxt.kind;
        block_low <= nxt.low;
        block_high <= nxt.high;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          if ($urandom_range(0, 2) == 0) begin
            gap_left <= 0;
          end else if ($urandom_range(0, 4) == 0) begin
            gap_left <= $urandom_range(5, 24);
          end else begin
            gap_left <= $urandom_range(1, 4);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        ready_left <= $urandom_range(1, 60);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= 1'b0;
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: key mirror, prediction on request accept, result check
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      key_copy <= '0;
      request_taken <= 1'b0;
    end else begin
      request_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        results_due.push_back(tea_cipher(kind, block_low, block_high, key_copy));
      end
      if (wr_en) begin
        case (wr_index)
          REG_KEY0: key_copy.w0 <= wr_data;
          REG_KEY1: key_copy.w1 <= wr_data;
          REG_KEY2: key_copy.w2 <= wr_data;
          REG_KEY3: key_copy.w3 <= wr_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual low %h high %h",
                   $time, result_low, result_high);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (result_low !== want.low) begin
            $display("%0t: result_low mismatch, expected %h, actual %h",
                     $time, want.low, result_low);
            mismatch_count++;
          end
          if (result_high !== want.high) begin
            $display("%0t: result_high mismatch, expected %h, actual %h",
                     $time, want.high, result_high);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic load_key(key_t k);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_KEY0;
    wr_data <= k.w0;
    @(negedge clk);
    wr_index <= REG_KEY1;
    wr_data <= k.w1;
    @(negedge clk);
    wr_index <= REG_KEY2;
    wr_data <= k.w2;
    @(negedge clk);
    wr_index <= REG_KEY3;
    wr_data <= k.w3;
    @(negedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (!(pending_reqs.size() == 0 && !in_valid && results_due.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  task automatic push_req(logic dir, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    block_req_t r;
    r.kind = dir;
    r.low = lo;
    r.high = hi;
    pending_reqs.push_back(r);
  endtask

  // encrypt a block, then decrypt the predicted ciphertext back
  task automatic push_round_trip(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    result_t c;
    c = tea_cipher(KIND_ENC, lo, hi, key_copy);
    push_req(KIND_ENC, lo, hi);
    push_req(KIND_DEC, c.low, c.high);
  endtask

  initial begin
    key_t k;
    int   sel;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    load_key('0);
    for (int d = 0; d < 2; d++) begin
      push_req(d[0], 32'h0000_0000, 32'h0000_0000);
      push_req(d[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(d[0], 32'h0000_0000, 32'hFFFF_FFFF);
      push_req(d[0], 32'hFFFF_FFFF, 32'h0000_0000);
      push_req(d[0], 32'hAAAA_AAAA, 32'h5555_5555);
      push_req(d[0], 32'h8000_0000, 32'h0000_0001);
      push_req(d[0], 32'h0000_0001, 32'h8000_0000);
    end
    push_round_trip(32'h0123_4567, 32'h89AB_CDEF);
    push_round_trip(32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: k = '1;
        1: k = {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        2: k = {32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210};
        7: k = '0;
        default: k = {pick_word(), pick_word(), pick_word(), pick_word()};
      endcase
      load_key(k);
      for (int i = 0; i < 212; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          push_round_trip(pick_word(), pick_word());
          i++;
        end else if (sel < 4) begin
          push_req(1'($urandom_range(0, 1)), pick_word(), pick_word());
        end else begin
          push_req(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
      end
      wait_idle();
    end

    repeat (2 * CYCLES + 8) @(negedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
